[rtl/lcmm_pkg.sv]
// LIN channel mode manager: shared types, event and register codes.
// Used by lcmm_step and lin_channel_mode_manager_core; no dependencies.

package lcmm_pkg;

   // event kinds (req_tuser)
   typedef enum logic [2:0] {
      KIND_MODE_REQ   = 3'd0,
      KIND_TICK       = 3'd1,
      KIND_WAKE_CONF  = 3'd2,
      KIND_SLEEP_IND  = 3'd3,
      KIND_SLEEP_CONF = 3'd4,
      KIND_SCHED_REQ  = 3'd5,
      KIND_SCHED_CONF = 3'd6,
      KIND_QUERY      = 3'd7
   } kind_type;

   localparam logic [1:0] MODE_NO_COMM = 2'd0;
   localparam logic [1:0] MODE_FULL    = 2'd1;

   // csr register indexes
   localparam logic [1:0] CSR_CONFIRM_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_SILENCE_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_RETRY_MAX       = 2'd2;
   localparam logic [1:0] CSR_IS_SLAVE        = 2'd3;

   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [2:0] {
      TK_NONE    = 3'b001,
      TK_WAKE    = 3'b010,
      TK_SILENCE = 3'b100
   } timer_kind_type;

   typedef enum logic [2:0] {
      RQ_NOTHING = 3'b001,
      RQ_WAKE    = 3'b010,
      RQ_SLEEP   = 3'b100
   } request_type;

   typedef struct packed {
      logic [15:0] confirm_timeout;
      logic [15:0] silence_timeout;
      logic [7:0]  retry_max;
      logic        is_slave;
   } cfg_type;

   typedef struct packed {
      logic           mode_full;
      logic           going_to_sleep;
      logic [15:0]    timer_count;
      timer_kind_type timer_kind;
      request_type    running_request;
      logic [7:0]     retry_count;
      logic           pending_mode_full;
      logic           pending_flag;
      logic [3:0]     current_schedule;
      logic           report_pending;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] req_mode;
      logic       success;
      logic       lower_accept;
      logic [3:0] schedule_id;
   } event_type;

   typedef struct packed {
      logic       status_ok;
      logic       current_full;
      logic       send_wakeup;
      logic       send_sleep;
      logic       send_schedule;
      logic       indicate_valid;
      logic       indicate_full;
      logic       sched_report_valid;
      logic [3:0] reported_schedule;
      logic       timeout_error;
   } result_type;

endpackage

[rtl/lin_channel_mode_manager_core.sv]
// LIN channel mode manager, top level: event stream in, result stream out.
// Holds channel state, configuration and the result register; uses lcmm_pkg, lcmm_step.
//
// Every event beat produces exactly one result beat, valid in the cycle after
// it is accepted. The whole state update is a single combinational pass, so a
// new event is accepted in every cycle in which the result register is empty
// or being drained; throughput is then one beat per cycle.
// Configuration writes are taken at any edge with csr_we high and must only
// be issued while no event is in flight.

module lin_channel_mode_manager_core #(
   parameter int SCHEDULE_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // kind
   input  logic [7:0]  req_tdata,   // req_mode[1:0], success, lower_accept, schedule_id[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status_ok, current_full, send_wakeup, send_sleep,
                                    // send_schedule, indicate_valid, indicate_full,
                                    // sched_report_valid, reported_schedule[3:0],
                                    // timeout_error, zero pad
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [lcmm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   lcmm_pkg::cfg_type    cfg_ff;
   lcmm_pkg::state_type  state_ff;
   lcmm_pkg::state_type  state_in;
   lcmm_pkg::event_type  evt;
   lcmm_pkg::result_type result;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic [15:0]          rsp_data_in;
   logic                 req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign evt.kind         = lcmm_pkg::kind_type'(req_tuser);
   assign evt.req_mode     = req_tdata[1:0];
   assign evt.success      = req_tdata[2];
   assign evt.lower_accept = req_tdata[3];
   assign evt.schedule_id  = req_tdata[7:4];

   lcmm_step #(
      .SCHEDULE_BITS(SCHEDULE_BITS)
   ) u_step (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .evt      (evt),
      .state_nx (state_in),
      .result   (result)
   );

   assign rsp_data_in = {3'b000,
                         result.timeout_error,
                         result.reported_schedule,
                         result.sched_report_valid,
                         result.indicate_full,
                         result.indicate_valid,
                         result.send_schedule,
                         result.send_sleep,
                         result.send_wakeup,
                         result.current_full,
                         result.status_ok};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            lcmm_pkg::CSR_CONFIRM_TIMEOUT: cfg_ff.confirm_timeout <= csr_wdata[15:0];
            lcmm_pkg::CSR_SILENCE_TIMEOUT: cfg_ff.silence_timeout <= csr_wdata[15:0];
            lcmm_pkg::CSR_RETRY_MAX:       cfg_ff.retry_max       <= csr_wdata[7:0];
            lcmm_pkg::CSR_IS_SLAVE:        cfg_ff.is_slave        <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode_full         <= 1'b0;
         state_ff.going_to_sleep    <= 1'b0;
         state_ff.timer_count       <= 16'd0;
         state_ff.timer_kind        <= lcmm_pkg::TK_NONE;
         state_ff.running_request   <= lcmm_pkg::RQ_NOTHING;
         state_ff.retry_count       <= 8'd0;
         state_ff.pending_mode_full <= 1'b0;
         state_ff.pending_flag      <= 1'b0;
         state_ff.current_schedule  <= 4'd0;
         state_ff.report_pending    <= 1'b0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/lcmm_step.sv]
// LIN channel mode manager: next state and result for one event beat.
// Purely combinational; depends on lcmm_pkg.

module lcmm_step #(
   parameter int SCHEDULE_BITS = 4
) (
   input  lcmm_pkg::cfg_type    cfg,
   input  lcmm_pkg::state_type  state,
   input  lcmm_pkg::event_type  evt,
   output lcmm_pkg::state_type  state_nx,
   output lcmm_pkg::result_type result
);

   localparam logic [3:0] SCHED_MASK =
      (SCHEDULE_BITS >= 4) ? 4'hF : 4'((1 << SCHEDULE_BITS) - 1);

   logic nx_full;
   logic ok;
   logic wants_full;
   logic wake_go;
   logic wake_load;
   logic wake_one_shot;

   always_comb begin
      state_nx      = state;
      result        = '0;
      nx_full       = 1'b0;
      ok            = 1'b0;
      wake_go       = 1'b0;
      wake_load     = 1'b0;
      wake_one_shot = 1'b0;
      wants_full    = state.pending_flag & state.pending_mode_full;

      case (evt.kind)
         lcmm_pkg::KIND_MODE_REQ: begin
            if (evt.req_mode == lcmm_pkg::MODE_NO_COMM ||
                evt.req_mode == lcmm_pkg::MODE_FULL) begin
               nx_full = (evt.req_mode == lcmm_pkg::MODE_FULL);
               if (nx_full && (!cfg.is_slave ||
                     !(state.timer_kind == lcmm_pkg::TK_SILENCE &&
                       state.timer_count != 16'd0))) begin
                  wake_go       = 1'b1;
                  wake_load     = evt.lower_accept;
                  wake_one_shot = 1'b1;
                  ok            = evt.lower_accept;
               end
               if (!nx_full && state.mode_full && !state.going_to_sleep) begin
                  if (!cfg.is_slave) begin
                     result.send_sleep = 1'b1;
                     if (evt.lower_accept) begin
                        state_nx.going_to_sleep  = 1'b1;
                        state_nx.running_request = lcmm_pkg::RQ_SLEEP;
                     end else begin
                        state_nx.running_request = lcmm_pkg::RQ_NOTHING;
                     end
                     ok = evt.lower_accept;
                  end else begin
                     ok = 1'b1;
                  end
                  if (!ok) begin
                     result.indicate_valid = 1'b1;
                     result.indicate_full  = 1'b1;
                  end
               end
               state_nx.pending_mode_full = nx_full;
               state_nx.pending_flag      = 1'b1;
               result.status_ok           = ok;
            end
         end
         lcmm_pkg::KIND_TICK: begin
            if (state.timer_count != 16'd0) begin
               state_nx.timer_count = state.timer_count - 16'd1;
            end
            if (state.running_request == lcmm_pkg::RQ_WAKE &&
                state_nx.timer_count == 16'd0) begin
               if (state.timer_kind == lcmm_pkg::TK_WAKE) begin
                  if (cfg.retry_max != 8'd0) begin
                     if (state.retry_count == 8'd0) begin
                        result.timeout_error = 1'b1;
                        if (cfg.is_slave) begin
                           state_nx.timer_count = cfg.silence_timeout;
                           state_nx.timer_kind  = lcmm_pkg::TK_SILENCE;
                        end else begin
                           state_nx.retry_count = cfg.retry_max;
                        end
                     end else begin
                        state_nx.retry_count = state.retry_count - 8'd1;
                     end
                  end
                  if (wants_full && state_nx.timer_kind != lcmm_pkg::TK_SILENCE) begin
                     wake_go   = 1'b1;
                     wake_load = 1'b1;
                  end
               end else if (state.timer_kind == lcmm_pkg::TK_SILENCE) begin
                  if (wants_full) begin
                     state_nx.timer_kind  = lcmm_pkg::TK_WAKE;
                     state_nx.timer_count = cfg.confirm_timeout;
                     state_nx.retry_count = cfg.retry_max;
                  end else begin
                     state_nx.timer_kind  = lcmm_pkg::TK_NONE;
                     state_nx.timer_count = 16'd0;
                  end
               end
            end
            if (state.report_pending) begin
               state_nx.report_pending  = 1'b0;
               result.sched_report_valid = 1'b1;
               result.reported_schedule  = state.current_schedule;
            end
         end
         lcmm_pkg::KIND_WAKE_CONF: begin
            if (state.running_request == lcmm_pkg::RQ_WAKE) begin
               state_nx.timer_count     = 16'd0;
               state_nx.timer_kind      = lcmm_pkg::TK_NONE;
               state_nx.running_request = lcmm_pkg::RQ_NOTHING;
               result.indicate_valid    = 1'b1;
               if (evt.success) begin
                  state_nx.mode_full      = 1'b1;
                  state_nx.going_to_sleep = 1'b0;
                  state_nx.pending_flag   = 1'b0;
                  result.indicate_full    = 1'b1;
               end
            end
         end
         lcmm_pkg::KIND_SLEEP_IND: begin
            if (state.mode_full) begin
               result.send_sleep = 1'b1;
               if (evt.lower_accept) begin
                  state_nx.going_to_sleep  = 1'b1;
                  state_nx.running_request = lcmm_pkg::RQ_SLEEP;
               end else begin
                  state_nx.running_request = lcmm_pkg::RQ_NOTHING;
               end
            end
         end
         lcmm_pkg::KIND_SLEEP_CONF: begin
            if (state.running_request == lcmm_pkg::RQ_SLEEP) begin
               if (!state.pending_mode_full) begin
                  state_nx.running_request = lcmm_pkg::RQ_NOTHING;
                  state_nx.pending_flag    = 1'b0;
                  state_nx.going_to_sleep  = 1'b0;
                  state_nx.mode_full       = 1'b0;
                  result.indicate_valid    = 1'b1;
               end else begin
                  wake_go   = 1'b1;
                  wake_load = 1'b1;
               end
            end
         end
         lcmm_pkg::KIND_SCHED_REQ: begin
            if (state.mode_full) begin
               result.send_schedule = 1'b1;
               result.status_ok     = evt.lower_accept;
               if (!evt.lower_accept) begin
                  state_nx.report_pending = 1'b1;
               end
            end
         end
         lcmm_pkg::KIND_SCHED_CONF: begin
            state_nx.current_schedule = evt.schedule_id & SCHED_MASK;
            state_nx.report_pending   = 1'b1;
         end
         lcmm_pkg::KIND_QUERY: begin
            result.status_ok    = 1'b1;
            result.current_full = state.mode_full;
         end
         default: begin
            result = '0;
         end
      endcase

      // wakeup start, shared by mode request, tick and sleep confirmation
      if (wake_go) begin
         result.send_wakeup = 1'b1;
         if (wake_load) begin
            state_nx.timer_count     = cfg.confirm_timeout;
            state_nx.timer_kind      = lcmm_pkg::TK_WAKE;
            state_nx.running_request = lcmm_pkg::RQ_WAKE;
            if (wake_one_shot) begin
               state_nx.retry_count = cfg.retry_max;
            end
         end
         if (state_nx.timer_count == 16'd0) begin
            state_nx.timer_kind = lcmm_pkg::TK_NONE;
         end
      end
   end

endmodule
